@@ hdl/oaht_pkg.sv @@
// shared constants and types for the open addressing hash table
`default_nettype none
package oaht_pkg;
   localparam int TABLE_DEPTH = 128;
   localparam int SLOT_W = $clog2(TABLE_DEPTH);
   localparam int SIZE_W = SLOT_W + 1;
   localparam int KEY_W = 31;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_CROWDED   = 3'd4;

   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_SIZE  = 2'd1;
   localparam logic [1:0] REG_PRIME = 2'd2;

   typedef struct packed {
      logic start;     // latch key, begin home reduction
      logic mod_step;  // one division step, or one size subtraction
      logic fold;      // take reduced remainder as home and probe slot
      logic read;      // memory read issued this cycle
      logic advance;   // move to next probe slot
      logic write;     // store key at current slot
   } cmd_type;

   typedef struct packed {
      logic mod_done;
      logic used;      // current slot occupied
      logic match;     // current slot holds key
      logic exhausted; // collisions reached size
      logic is_search;
      logic can_insert;
   } sts_type;
endpackage
`default_nettype wire

@@ hdl/oaht_if.sv @@
// valid/ready channel interfaces
`default_nettype none
interface oaht_req_if;
   logic req_valid;
   logic req_ready;
   logic req_type;
   logic [30:0] req_key;
   modport source(output req_valid, req_type, req_key, input req_ready);
   modport sink(input req_valid, req_type, req_key, output req_ready);
endinterface

interface oaht_rsp_if;
   logic rsp_valid;
   logic rsp_ready;
   logic [2:0] rsp_status;
   logic [6:0] rsp_position;
   logic [7:0] rsp_probe_count;
   modport source(output rsp_valid, rsp_status, rsp_position, rsp_probe_count,
                  input rsp_ready);
   modport sink(input rsp_valid, rsp_status, rsp_position, rsp_probe_count,
                output rsp_ready);
endinterface

interface oaht_csr_if;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [7:0] csr_data;
   modport source(output csr_valid, csr_index, csr_data, input csr_ready);
   modport sink(input csr_valid, csr_index, csr_data, output csr_ready);
endinterface
`default_nettype wire

@@ hdl/oaht_datapath.sv @@
// key reduction, probe sequencing and slot memory
`default_nettype none
module oaht_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire oaht_pkg::cmd_type cmd,
   output oaht_pkg::sts_type sts,
   input  wire logic req_type,
   input  wire logic [30:0] key,
   input  wire logic csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_data,
   output logic [2:0] status,
   output logic [6:0] position,
   output logic [7:0] probe_count
);
   import oaht_pkg::*;

   logic mode_ff;
   logic [7:0] size_reg_ff, prime_reg_ff;
   logic [SIZE_W-1:0] size_eff;
   logic [7:0] prime_eff;

   logic search_ff;
   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] quot_ff;   // dividend bits shifted out msb first
   logic [7:0] rem_ff;
   logic [4:0] bit_ff;
   logic mod_done_ff;
   logic folding_ff;
   logic [SLOT_W-1:0] home_ff, pos_ff;
   logic [SIZE_W:0] coll_ff;
   logic [SIZE_W-1:0] lin_off_ff;     // n mod size
   logic [SIZE_W-1:0] sq_off_ff;      // m*m mod size
   logic [SIZE_W-1:0] odd_ff;         // (2m+1) mod size
   logic [TABLE_DEPTH-1:0] used_ff;
   logic [KEY_W-1:0] mem [TABLE_DEPTH];
   logic [KEY_W-1:0] rd_key_ff;
   logic rd_used_ff;

   logic [8:0] trial;
   logic [7:0] rem_in;
   logic [SIZE_W:0] next_coll;

   // incremental offsets, all values kept below size
   logic [SIZE_W-1:0] lin_next, sq_next, odd_next;
   logic [SIZE_W:0] lsum, ssum, osum, psum, qsum;
   logic [SIZE_W-1:0] off, adv_pos;

   always_comb begin
      size_eff = (size_reg_ff == 8'd0) ? SIZE_W'(1) :
                 ({1'b0, size_reg_ff} > 9'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH) :
                 SIZE_W'(size_reg_ff);
      prime_eff = (prime_reg_ff == 8'd0) ? 8'd1 : prime_reg_ff;
      trial = {rem_ff, quot_ff[KEY_W-1]} - {1'b0, prime_eff};
      rem_in = trial[8] ? {rem_ff[6:0], quot_ff[KEY_W-1]} : trial[7:0];
      next_coll = coll_ff + 1'b1;
   end

   // home: key mod prime, then mod size; rem < 256, size >= 1, one subtract a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         size_reg_ff <= 8'd16;
         prime_reg_ff <= 8'd13;
         used_ff <= '0;
         mod_done_ff <= 1'b0;
         folding_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_MODE:  mode_ff <= csr_data[0];
               REG_SIZE:  size_reg_ff <= csr_data;
               REG_PRIME: prime_reg_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.start) begin
            key_ff <= key;
            quot_ff <= key;
            search_ff <= req_type;
            rem_ff <= 8'd0;
            bit_ff <= 5'd0;
            mod_done_ff <= 1'b0;
            folding_ff <= 1'b0;
         end else if (cmd.mod_step) begin
            if (!folding_ff) begin
               rem_ff <= rem_in;
               quot_ff <= {quot_ff[KEY_W-2:0], 1'b0};
               bit_ff <= bit_ff + 1'b1;
               if (bit_ff == 5'd30) begin
                  folding_ff <= 1'b1;
               end
            end else begin
               if ({1'b0, rem_ff} >= 9'(size_eff)) begin
                  rem_ff <= rem_ff - 8'(size_eff);
               end else begin
                  mod_done_ff <= 1'b1;
               end
            end
         end
         if (cmd.fold) begin
            home_ff <= SLOT_W'(rem_ff);
            pos_ff <= SLOT_W'(rem_ff);
            coll_ff <= '0;
            lin_off_ff <= '0;
            sq_off_ff <= '0;
            odd_ff <= (size_eff == SIZE_W'(1)) ? '0 : SIZE_W'(1);
         end
         if (cmd.read) begin
            rd_key_ff <= mem[pos_ff];
            rd_used_ff <= used_ff[pos_ff];
         end
         if (cmd.advance) begin
            coll_ff <= next_coll;
            pos_ff <= SLOT_W'(adv_pos);
            lin_off_ff <= lin_next;
            if (!coll_ff[0]) begin
               // odd collision number: new m, update square
               sq_off_ff <= sq_next;
               odd_ff <= odd_next;
            end
         end
         if (cmd.write) begin
            used_ff[pos_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[pos_ff] <= key_ff;
      end
   end

   always_comb begin
      lsum = {1'b0, lin_off_ff} + 1'b1;
      lin_next = (lsum >= {1'b0, size_eff}) ? SIZE_W'(lsum - {1'b0, size_eff}) :
                 lsum[SIZE_W-1:0];
      ssum = {1'b0, sq_off_ff} + {1'b0, odd_ff};
      sq_next = (ssum >= {1'b0, size_eff}) ? SIZE_W'(ssum - {1'b0, size_eff}) :
                ssum[SIZE_W-1:0];
      osum = {1'b0, odd_ff} + 2'd2;
      if (osum >= {1'b0, size_eff}) osum = osum - {1'b0, size_eff};
      if (osum >= {1'b0, size_eff}) osum = osum - {1'b0, size_eff};
      odd_next = osum[SIZE_W-1:0];
      if (!mode_ff) begin
         off = lin_next;
         psum = {2'b0, home_ff} + {1'b0, off};
      end else if (!coll_ff[0]) begin
         off = sq_next;
         psum = {2'b0, home_ff} + {1'b0, off};
      end else begin
         off = sq_off_ff;
         psum = {2'b0, home_ff} + {1'b0, size_eff} - {1'b0, off};
      end
      qsum = (psum >= {1'b0, size_eff}) ? psum - {1'b0, size_eff} : psum;
      adv_pos = qsum[SIZE_W-1:0];
   end

   always_comb begin
      sts.mod_done = mod_done_ff;
      sts.used = rd_used_ff;
      sts.match = rd_used_ff && (rd_key_ff == key_ff);
      sts.exhausted = coll_ff >= {1'b0, size_eff};
      sts.is_search = search_ff;
      sts.can_insert = (coll_ff < {2'b0, size_eff[SIZE_W-1:1]}) && !rd_used_ff;
      position = 7'(pos_ff);
      probe_count = (coll_ff > (SIZE_W+1)'(255)) ? 8'd255 : 8'(coll_ff);
      if (search_ff) status = sts.match ? ST_FOUND : ST_NOT_FOUND;
      else if (sts.match) status = ST_DUPLICATE;
      else if (sts.can_insert) status = ST_INSERTED;
      else status = ST_CROWDED;
   end
endmodule
`default_nettype wire

@@ hdl/oaht_control.sv @@
// sequencing state machine for one request
`default_nettype none
module oaht_control (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_fire,
   input  wire logic rsp_ready,
   input  wire oaht_pkg::sts_type sts,
   output oaht_pkg::cmd_type cmd,
   output logic busy,
   output logic rsp_valid
);
   import oaht_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MOD  = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_TEST = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.start = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (sts.mod_done) begin
               cmd.fold = 1'b1;
               state_in = S_READ;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_TEST;
         end
         S_TEST: begin
            if (sts.used && !sts.match && !sts.exhausted) begin
               cmd.advance = 1'b1;
               state_in = S_READ;
            end else begin
               cmd.write = !sts.is_search && !sts.match && sts.can_insert;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;
endmodule
`default_nettype wire

@@ hdl/open_addressing_hash_table_unit.sv @@
// top level of the open addressing hash table
// flow: from an accepted item the unit divides the key by the prime, one restoring
// division step for each of the 31 key bits, then subtracts the size (one a cycle)
// until the remainder is below it, none when prime <= size, then reads and tests
// one probe slot after another; throughput: one item at a time
// reset: synchronous, clears all slot valid bits and restores linear probing, size 16, prime 13
`default_nettype none
module open_addressing_hash_table_unit (
   input wire logic clock,
   input wire logic reset,
   oaht_req_if.sink req,
   oaht_rsp_if.source rsp,
   oaht_csr_if.sink csr
);
   import oaht_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic busy;
   logic rsp_valid_w;

   // item taken only while idle
   assign req.req_ready = !busy;
   // registers written only when no item is in flight
   assign csr.csr_ready = !busy;
   assign rsp.rsp_valid = rsp_valid_w;

   oaht_control u_control (
      .clock(clock), .reset(reset),
      .req_fire(req.req_valid && !busy),
      .rsp_ready(rsp.rsp_ready),
      .sts(sts), .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid_w)
   );

   oaht_datapath u_datapath (
      .clock(clock), .reset(reset),
      .cmd(cmd), .sts(sts),
      .req_type(req.req_type), .key(req.req_key),
      .csr_we(csr.csr_valid && !busy), .csr_index(csr.csr_index), .csr_data(csr.csr_data),
      .status(rsp.rsp_status), .position(rsp.rsp_position),
      .probe_count(rsp.rsp_probe_count)
   );
endmodule
`default_nettype wire

@@ hdl/oaht_checker.sv @@
// port level checks, bound to the top level
`default_nettype none
module oaht_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [2:0] status
);
   import oaht_pkg::*;
   a_no_accept_while_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken with result pending");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status <= ST_CROWDED) else $error("bad status");
   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("result too early");
endmodule

bind open_addressing_hash_table_unit oaht_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.req_valid), .req_ready(req.req_ready),
   .rsp_valid(rsp.rsp_valid), .rsp_ready(rsp.rsp_ready), .status(rsp.rsp_status)
);
`default_nettype wire

@@ test/oaht_checker.sv @@
// checker: predicts hash table responses and compares them with the block's output
module oaht_scoreboard
   import oaht_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   oaht_req_if            req,
   oaht_rsp_if            rsp,
   oaht_csr_if            csr,
   output int             fail_count,
   output int             pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] position;
      logic [7:0] probe_count;
   } lookup_result_type;

   logic             probe_mode;
   logic [7:0]       table_size;
   logic [7:0]       prime_modulus;
   logic             slot_used [TABLE_DEPTH];
   logic [KEY_W-1:0] slot_key [TABLE_DEPTH];
   lookup_result_type expected_q[$];

   // slot reached after collision n from home
   function automatic int probe_slot(int home, int n, int size);
      int m;
      int off;
      if (!probe_mode) return (home + (n % size)) % size;
      m = (n + 1) / 2;
      off = (m * m) % size;
      if (n % 2) return (home + off) % size;
      return (home + size - off) % size;
   endfunction

   function automatic lookup_result_type lookup(logic is_search, logic [KEY_W-1:0] key);
      lookup_result_type r;
      int size;
      int prime;
      int home;
      int pos;
      int coll;
      logic hit;
      size = (table_size == 0) ? 1 : int'(table_size);
      if (size > TABLE_DEPTH) size = TABLE_DEPTH;
      prime = (prime_modulus == 0) ? 1 : int'(prime_modulus);
      home = int'(longint'(key) % prime) % size;
      pos = home;
      coll = 0;
      while (slot_used[pos] && slot_key[pos] != key && coll < size) begin
         coll++;
         pos = probe_slot(home, coll, size);
      end
      hit = slot_used[pos] && slot_key[pos] == key;
      if (is_search) begin
         r.status = hit ? ST_FOUND : ST_NOT_FOUND;
      end else if (hit) begin
         r.status = ST_DUPLICATE;
      end else if (coll < size / 2 && !slot_used[pos]) begin
         slot_used[pos] = 1'b1;
         slot_key[pos] = key;
         r.status = ST_INSERTED;
      end else begin
         r.status = ST_CROWDED;
      end
      r.position = pos[6:0];
      r.probe_count = (coll > 255) ? 8'd255 : coll[7:0];
      return r;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         probe_mode <= 1'b0;
         table_size <= 8'd16;
         prime_modulus <= 8'd13;
         for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (csr.csr_valid && csr.csr_ready) begin
            case (csr.csr_index)
               REG_MODE:  probe_mode <= csr.csr_data[0];
               REG_SIZE:  table_size <= csr.csr_data;
               REG_PRIME: prime_modulus <= csr.csr_data;
               default: ;
            endcase
         end
         if (req.req_valid && req.req_ready)
            expected_q.push_back(lookup(req.req_type, req.req_key));
         if (rsp.rsp_valid && rsp.rsp_ready) begin
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %0d/%0d/%0d",
                  rsp.rsp_status, rsp.rsp_position, rsp.rsp_probe_count);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (want != {rsp.rsp_status, rsp.rsp_position, rsp.rsp_probe_count}) begin
                  if (fail_count < 10)
                     $display("mismatch: expected st %0d pos %0d coll %0d, got %0d %0d %0d",
                        want.status, want.position, want.probe_count,
                        rsp.rsp_status, rsp.rsp_position, rsp.rsp_probe_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ test/tb_top.sv @@
// testbench top: stimulus for the hash table unit and the final verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import oaht_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   quiet_cycles;
   bit   calm_mode;       // stretch with no idling on either side
   bit   hold_rsp;        // long receiver hold-off
   logic [KEY_W-1:0] key_pool[$];

   oaht_req_if req_ch();
   oaht_rsp_if rsp_ch();
   oaht_csr_if csr_ch();

   open_addressing_hash_table_unit dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source), .csr(csr_ch.sink));

   oaht_scoreboard checker_i (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch),
      .fail_count(fail_count), .pending_count(pending_count));

   always #1 clock = ~clock;

   initial begin
      req_ch.req_valid = 1'b0;
      req_ch.req_type = 1'b0;
      req_ch.req_key = '0;
      rsp_ch.rsp_ready = 1'b0;
      csr_ch.csr_valid = 1'b0;
      csr_ch.csr_index = REG_MODE;
      csr_ch.csr_data = '0;
   end

   // receiver: random stalls, none in calm stretches, a long hold when asked
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_ch.rsp_ready <= 1'b0;
      end else begin
         rsp_ch.rsp_ready <= calm_mode || ($urandom_range(99) >= 24);
      end
   end

   // watchdog: cycles without any handshake on request, response or registers
   always @(posedge clock) begin
      if (reset || (req_ch.req_valid && req_ch.req_ready) ||
          (rsp_ch.rsp_valid && rsp_ch.rsp_ready) || (csr_ch.csr_valid && csr_ch.csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [1:0] index, logic [7:0] value);
      @(posedge clock);
      csr_ch.csr_valid <= 1'b1;
      csr_ch.csr_index <= index;
      csr_ch.csr_data <= value;
      do @(posedge clock); while (!csr_ch.csr_ready);
      csr_ch.csr_valid <= 1'b0;
   endtask

   // one request item, with a random gap in front unless calm
   // valid stays high after the accept so items can follow back to back
   task automatic send_request(logic is_search, logic [KEY_W-1:0] key);
      while (!calm_mode && $urandom_range(99) < 24) begin
         req_ch.req_valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.req_valid <= 1'b1;
      req_ch.req_type <= is_search;
      req_ch.req_key <= key;
      do @(posedge clock); while (!req_ch.req_ready);
      if (!is_search) key_pool.push_back(key);
   endtask

   // drop valid and wait for the block to drain before touching registers
   // the block is busy in the cycle after an accept, so no item is taken twice
   task automatic drain();
      @(posedge clock);
      req_ch.req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // mostly keys already seen or sharing a home slot, for deep probe chains
   function automatic logic [KEY_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4 && key_pool.size() > 0) return key_pool[$urandom_range(key_pool.size() - 1)];
      if (sel < 8) return KEY_W'($urandom_range(300));
      return KEY_W'({$urandom, $urandom} >> 1);
   endfunction

   task automatic random_phase(int count, logic [7:0] mode, logic [7:0] size, logic [7:0] prime);
      drain();
      write_reg(REG_MODE, mode);
      write_reg(REG_SIZE, size);
      write_reg(REG_PRIME, prime);
      for (int i = 0; i < count; i++) begin
         send_request($urandom_range(99) < 40, pick_key());
      end
   endtask

   initial begin
      calm_mode = 1'b0;
      hold_rsp = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: key extremes, duplicates, collisions, search misses at reset settings
      send_request(1'b1, '0);
      send_request(1'b0, '0);
      send_request(1'b0, '0);
      send_request(1'b1, '0);
      send_request(1'b0, {KEY_W{1'b1}});
      send_request(1'b1, {KEY_W{1'b1}});
      send_request(1'b0, 31'h2aaaaaaa);
      send_request(1'b0, 31'h55555555);
      for (int i = 1; i <= 10; i++) send_request(1'b0, KEY_W'(13 * i));  // same home, crowds
      send_request(1'b1, KEY_W'(13 * 7));
      send_request(1'b1, KEY_W'(13 * 11));

      // receiver holds off long while requests keep coming
      fork
         begin
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 6; i++) send_request(1'($urandom_range(1)), pick_key());
      join

      // quadratic probing on the same table, then full search exhaustion
      random_phase(0, 8'd1, 8'd16, 8'd13);
      for (int i = 1; i <= 4; i++) send_request(1'b0, KEY_W'(13 * i + 1000));
      send_request(1'b1, KEY_W'(99999));

      // extremes of size and prime, including out-of-range values
      random_phase(150, 8'd0, 8'd128, 8'd127);
      random_phase(150, 8'd1, 8'd5, 8'd5);
      random_phase(150, 8'd0, 8'd0, 8'd0);
      random_phase(150, 8'd1, 8'd255, 8'd255);
      random_phase(150, 8'd0, 8'd8, 8'd2);
      calm_mode = 1'b1;
      random_phase(250, 8'd1, 8'd32, 8'd31);
      calm_mode = 1'b0;
      random_phase(200, 8'd0, 8'd11, 8'd11);
      random_phase(200, 8'd1, 8'd64, 8'd61);
      random_phase(200, 8'd0, 8'd20, 8'd19);
      random_phase(200, 8'd1, 8'd7, 8'd128);   // prime above size: folded again

      drain();
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end
endmodule

@@ sim.f @@
hdl/oaht_pkg.sv
hdl/oaht_if.sv
hdl/oaht_datapath.sv
hdl/oaht_control.sv
hdl/open_addressing_hash_table_unit.sv
hdl/oaht_checker.sv
test/oaht_checker.sv
test/tb_top.sv
